// ----- src/mmm_pkg.sv -----
// Shared types and constants for the matrix multiply engine.
`timescale 1ns / 1ps

package mmm_pkg;

	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = 48;
	localparam int SIZE_W = 5;

	typedef enum logic [1:0] {
		KIND_WR_A = 2'd0,
		KIND_WR_B = 2'd1,
		KIND_REQ  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// control for the multiply-accumulate unit, aligned with the read data
	typedef struct packed {
		logic clr;
		logic vld;
		logic last;
	} mac_ctrl_t;

endpackage

// ----- src/matrix_multiply_mac.sv -----
// Top level of the matrix multiply engine: element stores, sequencer, result register.
`timescale 1ns / 1ps

// Square matrix multiply engine. Each input word writes one Q8.8 element of A or B, asks
// for element (row, col) of C = A * B, or (kind none) does nothing. A request walks the
// row of A and the column of B through two stores, one term a cycle into a single
// multiply-accumulate, for n terms, n being the size in use. Writes and requests are held
// off while a request runs. The Q32.16 result sits in an output register, so further words
// are taken while it waits. The stores need no clearing after reset and read undefined
// data until written.
module matrix_multiply_mac #(
	parameter int DIM = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic [3:0]                           row,
	input  logic [3:0]                           col,
	input  logic signed [mmm_pkg::ELEM_W-1:0]    value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mmm_pkg::SUM_W-1:0]     sum,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mmm_pkg::SIZE_W-1:0]           size_in_use
);
	import mmm_pkg::*;

	localparam int DEPTH = DIM * DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW    = $clog2(DIM + 1);

	state_t                   state_q;
	logic [KW-1:0]            n_q;
	logic [KW-1:0]            k_q;
	logic [AW-1:0]            a_addr_q;
	logic [AW-1:0]            b_addr_q;
	logic signed [ELEM_W-1:0] a_mem [0:DEPTH-1];
	logic signed [ELEM_W-1:0] b_mem [0:DEPTH-1];
	logic signed [ELEM_W-1:0] a_rd_q;
	logic signed [ELEM_W-1:0] b_rd_q;
	logic                     vld_s1;
	logic                     last_s1;
	logic                     accept;
	logic                     in_store;
	logic                     in_size;
	logic [AW-1:0]            wr_addr;
	logic                     issue;
	logic                     issue_last;
	logic                     out_load;
	mac_ctrl_t                mac_ctrl;
	logic signed [SUM_W-1:0]  acc;
	logic                     mac_done;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			n_q <= KW'(DIM);
		else if (cfg_valid) begin
			priority if (size_in_use == '0)
				n_q <= KW'(1);
			else if (32'(size_in_use) > DIM)
				n_q <= KW'(DIM);
			else
				n_q <= KW'(size_in_use);
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid & ~in_stall;
	assign in_store   = (32'(row) < DIM) && (32'(col) < DIM);
	assign in_size    = (32'(row) < 32'(n_q)) && (32'(col) < 32'(n_q));
	assign wr_addr    = AW'(32'(row) * DIM + 32'(col));
	assign issue      = (state_q == ST_ISSUE);
	assign issue_last = issue && (k_q == n_q - KW'(1));
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// element stores, one write and one registered read each
	always_ff @(posedge clk) begin
		if (accept && in_store && kind == KIND_WR_A)
			a_mem[wr_addr] <= value;
		if (issue)
			a_rd_q <= a_mem[a_addr_q];
	end

	always_ff @(posedge clk) begin
		if (accept && in_store && kind == KIND_WR_B)
			b_mem[wr_addr] <= value;
		if (issue)
			b_rd_q <= b_mem[b_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= issue_last;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && kind == KIND_REQ) begin
						k_q     <= '0;
						state_q <= in_size ? ST_ISSUE : ST_DONE;
					end
				end
				ST_ISSUE: begin
					k_q <= k_q + KW'(1);
					if (issue_last)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mac_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// row of A steps by one, column of B steps by a whole row
	always_ff @(posedge clk) begin
		if (accept) begin
			a_addr_q <= AW'(32'(row) * DIM);
			b_addr_q <= AW'(col);
		end else if (issue) begin
			a_addr_q <= a_addr_q + AW'(1);
			b_addr_q <= b_addr_q + AW'(DIM);
		end
	end

	always_comb begin
		mac_ctrl.clr  = accept && (kind == KIND_REQ);
		mac_ctrl.vld  = vld_s1;
		mac_ctrl.last = last_s1;
	end

	mmm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (a_rd_q),
		.b      (b_rd_q),
		.acc    (acc),
		.done   (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			sum_q <= acc;
	end

	assign out_valid = out_valid_q;
	assign sum       = sum_q;

	a_rd_from_issue: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == ST_ISSUE))
		else $error("store read data flagged without an issue cycle");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_WAIT))
		else $error("final term accumulated outside the wait state");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word raised without a finished request");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (k_q < n_q))
		else $error("term counter ran past the size in use");

endmodule

// ----- src/mmm_mac.sv -----
// Pipelined signed multiply-accumulate with a saturating 48-bit total.
`timescale 1ns / 1ps

module mmm_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mmm_pkg::mac_ctrl_t                    ctrl,
	input  logic signed [mmm_pkg::ELEM_W-1:0]     a,
	input  logic signed [mmm_pkg::ELEM_W-1:0]     b,
	output logic signed [mmm_pkg::SUM_W-1:0]      acc,
	output logic                                  done
);
	import mmm_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic                     last_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W:0]    sum_ext;
	logic signed [SUM_W-1:0]  sum_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= ctrl.vld;
			last_s2 <= ctrl.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	always_comb begin
		sum_ext = {acc_q[SUM_W-1], acc_q} + (SUM_W+1)'(prod_s2);
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_ext[SUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr)
			acc_q <= '0;
		else if (vld_s2)
			acc_q <= sum_sat;
	end

	assign acc  = acc_q;
	// final term lands in the accumulator at this edge
	assign done = vld_s2 & last_s2;

endmodule

// ----- dv/matrix_multiply_mac_tb.sv -----
// Self-checking testbench for the matrix multiply engine: predicts every requested product element and checks it.
`timescale 1ns / 1ps

module matrix_multiply_mac_tb;
	import mmm_pkg::*;

	localparam int DIM         = 16;
	localparam int IDLE_PCT    = 23;
	localparam int SETTLE      = DIM + 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 10;
	localparam int WORD_TARGET = 1550;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               kind = KIND_NONE;
	logic [3:0]               row = '0;
	logic [3:0]               col = '0;
	logic signed [ELEM_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [SUM_W-1:0]  sum;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [SIZE_W-1:0]        size_in_use = SIZE_W'(DIM);

	// predictor copy of the element stores and the size register
	logic signed [ELEM_W-1:0] a_elem [DIM*DIM];
	logic signed [ELEM_W-1:0] b_elem [DIM*DIM];
	bit                       a_set  [DIM*DIM];
	bit                       b_set  [DIM*DIM];
	logic [SIZE_W-1:0]        size_reg = SIZE_W'(DIM);

	logic signed [SUM_W-1:0]  sum_queue [$];
	logic signed [SUM_W-1:0]  expected_sum;
	int                       words_sent   = 0;
	int                       sums_checked = 0;
	int                       fail_count   = 0;
	int                       sizes_run    = 0;
	int                       cycles       = 0;
	bit                       quiet        = 1'b0;

	always #6 clk = ~clk;

	matrix_multiply_mac #(
		.DIM(DIM)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.row        (row),
		.col        (col),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sum        (sum),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.size_in_use(size_in_use)
	);

	function automatic int span();
		if (size_reg == '0)
			return 1;
		if (size_reg > DIM)
			return DIM;
		return int'(size_reg);
	endfunction

	function automatic logic signed [SUM_W-1:0] dot_product(int r, int c);
		longint acc;
		longint lim_hi;
		longint lim_lo;
		int     n;
		n      = span();
		acc    = 0;
		lim_hi = (longint'(1) << (SUM_W - 1)) - 1;
		lim_lo = -lim_hi - 1;
		if (r < n && c < n) begin
			for (int k = 0; k < n; k++) begin
				acc += longint'(a_elem[r*DIM+k]) * longint'(b_elem[k*DIM+c]);
				if (acc > lim_hi)
					acc = lim_hi;
				else if (acc < lim_lo)
					acc = lim_lo;
			end
		end
		return acc[SUM_W-1:0];
	endfunction

	// true when the request reads only entries already written
	function automatic bit req_ready(int r, int c);
		int n;
		n = span();
		if (r >= n || c >= n)
			return 1'b1;
		for (int k = 0; k < n; k++)
			if (!a_set[r*DIM+k] || !b_set[k*DIM+c])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic signed [ELEM_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	task automatic predict_word(kind_t k, int r, int c, logic signed [ELEM_W-1:0] v);
		case (k)
			KIND_WR_A: begin
				a_elem[r*DIM+c] = v;
				a_set[r*DIM+c]  = 1'b1;
			end
			KIND_WR_B: begin
				b_elem[r*DIM+c] = v;
				b_set[r*DIM+c]  = 1'b1;
			end
			KIND_REQ: sum_queue.push_back(dot_product(r, c));
			default: ;
		endcase
	endtask

	task automatic send_word(kind_t k, int r, int c, logic signed [ELEM_W-1:0] v);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		row      <= 4'(r);
		col      <= 4'(c);
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_word(k, r, c, v);
		words_sent++;
	endtask

	// hold the input off until every pending sum is back and the engine has gone quiet
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sum_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] s);
		drain_results();
		cfg_valid   <= 1'b1;
		size_in_use <= s;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		size_reg = s;
		sizes_run++;
	endtask

	// load the n x n corner of A and B; entries already set are rewritten now and then
	task automatic fill_block(int n);
		int idx;
		for (int i = 0; i < n * n; i++) begin
			idx = (i / n) * DIM + (i % n);
			if (!a_set[idx] || $urandom_range(3) == 0)
				send_word(KIND_WR_A, i / n, i % n, pick_value());
			if (!b_set[idx] || $urandom_range(3) == 0)
				send_word(KIND_WR_B, i / n, i % n, pick_value());
			if ($urandom_range(15) == 0)
				send_word(KIND_NONE, $urandom_range(15), $urandom_range(15), ELEM_W'($urandom));
		end
	endtask

	task automatic random_traffic(int count);
		int n;
		int r;
		int c;
		int pick;
		n = span();
		repeat (count) begin
			pick = $urandom_range(99);
			r    = $urandom_range(n - 1);
			c    = $urandom_range(n - 1);
			if (pick < 2)
				drain_results();
			if (pick < 65) begin
				if (req_ready(r, c))
					send_word(KIND_REQ, r, c, ELEM_W'($urandom));
				else
					send_word(KIND_WR_A, r, c, pick_value());
			end else if (pick < 75) begin
				send_word(KIND_WR_A, r, c, pick_value());
			end else if (pick < 85) begin
				send_word(KIND_WR_B, r, c, pick_value());
			end else if (pick < 90) begin
				send_word(KIND_NONE, $urandom_range(15), $urandom_range(15), ELEM_W'($urandom));
			end else if (pick < 95) begin
				r = $urandom_range(15);
				c = $urandom_range(15);
				if (req_ready(r, c))
					send_word(KIND_REQ, r, c, ELEM_W'($urandom));
				else
					send_word(KIND_WR_B, r, c, pick_value());
			end else begin
				// anywhere in the store, often outside the size in use
				send_word($urandom_range(1) ? KIND_WR_A : KIND_WR_B,
					$urandom_range(15), $urandom_range(15), pick_value());
			end
		end
	endtask

	task automatic test_corner_values();
		write_size(SIZE_W'(1));
		send_word(KIND_WR_A, 0, 0, 16'sh8000);
		send_word(KIND_WR_B, 0, 0, 16'sh8000);
		send_word(KIND_REQ, 0, 0, '0);
		send_word(KIND_WR_A, 0, 0, 16'sh7FFF);
		send_word(KIND_REQ, 0, 0, 16'shFFFF);
		send_word(KIND_WR_B, 0, 0, 16'sh7FFF);
		send_word(KIND_REQ, 0, 0, '0);
		send_word(KIND_WR_A, 0, 0, 16'shFFFF);
		send_word(KIND_WR_B, 0, 0, 16'sh0001);
		send_word(KIND_REQ, 0, 0, '0);
		// outside the size in use: a zero sum comes back
		send_word(KIND_REQ, 0, 15, '0);
		send_word(KIND_REQ, 15, 0, '0);
		send_word(KIND_REQ, 15, 15, 16'sh7FFF);
		send_word(KIND_WR_A, 15, 15, 16'sh5A5A);
		send_word(KIND_WR_B, 9, 6, 16'shA5A5);
		send_word(KIND_NONE, 0, 0, 16'sh1234);
		send_word(KIND_REQ, 0, 0, '0);
		// size zero behaves as one
		write_size('0);
		send_word(KIND_REQ, 0, 0, '0);
		send_word(KIND_REQ, 1, 0, '0);
		send_word(KIND_WR_A, 0, 0, '0);
		send_word(KIND_REQ, 0, 0, '0);
	endtask

	task automatic test_full_size();
		write_size(SIZE_W'(DIM));
		fill_block(DIM);
		random_traffic(120);
	endtask

	// sizes above the store dimension behave as the full store
	task automatic test_oversize();
		write_size(SIZE_W'(31));
		random_traffic(60);
	endtask

	task automatic test_quiet_stretch();
		write_size(SIZE_W'(4));
		quiet = 1'b1;
		fill_block(4);
		random_traffic(80);
		quiet = 1'b0;
	endtask

	task automatic test_size_sweep();
		int r;
		logic [SIZE_W-1:0] s;
		while (words_sent < WORD_TARGET) begin
			r = $urandom_range(15);
			if (r < 11)
				s = SIZE_W'(1 + $urandom_range(7));
			else if (r == 11)
				s = '0;
			else if (r == 12)
				s = SIZE_W'(DIM + 1);
			else if (r == 13)
				s = SIZE_W'(31);
			else if (r == 14)
				s = SIZE_W'(12);
			else
				s = SIZE_W'(1 + $urandom_range(15));
			write_size(s);
			fill_block(span());
			random_traffic(40 + $urandom_range(40));
		end
	endtask

	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sum_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected sum word %0d with nothing pending", sum);
			end else begin
				expected_sum = sum_queue.pop_front();
				sums_checked++;
				if (sum !== expected_sum) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("sum mismatch: expected %0d, got %0d", expected_sum, sum);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sums pending", cycles, sum_queue.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_values();
		test_full_size();
		test_oversize();
		test_quiet_stretch();
		test_size_sweep();
		drain_results();
		fail_count += sum_queue.size();
		$display("%0d words over %0d size settings, %0d product elements checked",
			words_sent, sizes_run, sums_checked);
		$display("covered Q8.8 extremes, sizes 0 to 31, out-of-range requests and idle words");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
